// File: hdl/srclex_pkg.sv
// ----------------------------------------------------------------------------
// srclex_pkg
// Token codes, lexer modes, request types and character helpers shared by the
// source lexer front end, back end and checker.
// ----------------------------------------------------------------------------
package srclex_pkg;

    localparam logic [5:0] K_END    = 6'd0;
    localparam logic [5:0] K_SEMI   = 6'd1;
    localparam logic [5:0] K_LBRACK = 6'd2;
    localparam logic [5:0] K_RBRACK = 6'd3;
    localparam logic [5:0] K_LBRACE = 6'd4;
    localparam logic [5:0] K_RBRACE = 6'd5;
    localparam logic [5:0] K_INT    = 6'd6;
    localparam logic [5:0] K_COMMA  = 6'd7;
    localparam logic [5:0] K_STR    = 6'd8;
    localparam logic [5:0] K_STRCH  = 6'd9;
    localparam logic [5:0] K_CHR    = 6'd10;
    localparam logic [5:0] K_IDCH   = 6'd11;
    localparam logic [5:0] K_IDENT  = 6'd12;
    localparam logic [5:0] K_OUT    = 6'd13;
    localparam logic [5:0] K_IN     = 6'd14;
    localparam logic [5:0] K_GETL   = 6'd15;
    localparam logic [5:0] K_DECL   = 6'd16;
    localparam logic [5:0] K_TINT   = 6'd17;
    localparam logic [5:0] K_TCHR   = 6'd18;
    localparam logic [5:0] K_TSTR   = 6'd19;
    localparam logic [5:0] K_TLIST  = 6'd20;
    localparam logic [5:0] K_TBOOL  = 6'd21;
    localparam logic [5:0] K_TFUNC  = 6'd22;
    localparam logic [5:0] K_IF     = 6'd23;
    localparam logic [5:0] K_ELSE   = 6'd24;
    localparam logic [5:0] K_FOR    = 6'd25;
    localparam logic [5:0] K_WHILE  = 6'd26;
    localparam logic [5:0] K_BOOLV  = 6'd27;
    localparam logic [5:0] K_RET    = 6'd28;
    localparam logic [5:0] K_MOD    = 6'd29;
    localparam logic [5:0] K_XOR    = 6'd30;
    localparam logic [5:0] K_LOR    = 6'd31;
    localparam logic [5:0] K_BOR    = 6'd32;
    localparam logic [5:0] K_LAND   = 6'd33;
    localparam logic [5:0] K_BAND   = 6'd34;
    localparam logic [5:0] K_GE     = 6'd35;
    localparam logic [5:0] K_SHR    = 6'd36;
    localparam logic [5:0] K_GT     = 6'd37;
    localparam logic [5:0] K_LE     = 6'd38;
    localparam logic [5:0] K_SHL    = 6'd39;
    localparam logic [5:0] K_LT     = 6'd40;
    localparam logic [5:0] K_EQ     = 6'd41;
    localparam logic [5:0] K_ASSIGN = 6'd42;
    localparam logic [5:0] K_NE     = 6'd43;
    localparam logic [5:0] K_LPAR   = 6'd44;
    localparam logic [5:0] K_RPAR   = 6'd45;
    localparam logic [5:0] K_ADD    = 6'd46;
    localparam logic [5:0] K_SUB    = 6'd47;
    localparam logic [5:0] K_MUL    = 6'd48;
    localparam logic [5:0] K_DIV    = 6'd49;
    localparam logic [5:0] K_FAULT  = 6'd50;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_OPEN_STR = 3'd1;
    localparam logic [2:0] E_OPEN_CHR = 3'd2;
    localparam logic [2:0] E_LONG_CHR = 3'd3;
    localparam logic [2:0] E_BANG     = 3'd4;
    localparam logic [2:0] E_OVERFLOW = 3'd5;

    typedef enum logic [2:0] {
        M_IDLE,
        M_COMMENT,
        M_NUMBER,
        M_WORD,
        M_STRING,
        M_CHARLIT,
        M_PENDING,
        M_HALT
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [30:0] value;
        logic [2:0]  err;
    } tok_t;

    typedef struct packed {
        logic [4:0]       nflush;
        logic [1:0]       ntok;
        tok_t [2:0]       tok;
    } job_t;

    typedef struct packed {
        mode_t      mode;
        logic       emit;
        logic [5:0] kind;
    } st_t;

    typedef struct packed {
        logic [5:0] kind;
        logic       consumed;
        logic       bang;
    } rp_t;

    typedef struct packed {
        logic       hit;
        logic       two;
        logic [5:0] k1;
        logic [5:0] k2;
        logic [3:0] val;
    } kw_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic st_t start_class(input logic [7:0] c);
        st_t s;
        s.mode = M_IDLE;
        s.emit = 1'b0;
        s.kind = K_END;
        if (is_digit(c)) begin
            s.mode = M_NUMBER;
        end else if (is_alpha(c) || c == "_") begin
            s.mode = M_WORD;
        end else begin
            case (c)
                "#":  s.mode = M_COMMENT;
                "\"": s.mode = M_STRING;
                "'":  s.mode = M_CHARLIT;
                "|", "&", ">", "<", "=", "!": s.mode = M_PENDING;
                ";":  begin s.emit = 1'b1; s.kind = K_SEMI;   end
                "[":  begin s.emit = 1'b1; s.kind = K_LBRACK; end
                "]":  begin s.emit = 1'b1; s.kind = K_RBRACK; end
                "{":  begin s.emit = 1'b1; s.kind = K_LBRACE; end
                "}":  begin s.emit = 1'b1; s.kind = K_RBRACE; end
                ",":  begin s.emit = 1'b1; s.kind = K_COMMA;  end
                "%":  begin s.emit = 1'b1; s.kind = K_MOD;    end
                "^":  begin s.emit = 1'b1; s.kind = K_XOR;    end
                "(":  begin s.emit = 1'b1; s.kind = K_LPAR;   end
                ")":  begin s.emit = 1'b1; s.kind = K_RPAR;   end
                "+":  begin s.emit = 1'b1; s.kind = K_ADD;    end
                "-":  begin s.emit = 1'b1; s.kind = K_SUB;    end
                "*":  begin s.emit = 1'b1; s.kind = K_MUL;    end
                "/":  begin s.emit = 1'b1; s.kind = K_DIV;    end
                default: s.mode = M_IDLE;
            endcase
        end
        return s;
    endfunction

    function automatic rp_t resolve_op(input logic [7:0] p, input logic [7:0] c,
                                       input logic at_end);
        rp_t r;
        logic [7:0] cc;
        cc = at_end ? 8'd0 : c;
        r.consumed = 1'b0;
        r.bang = 1'b0;
        r.kind = K_END;
        case (p)
            "|": if (cc == "|") begin r.kind = K_LOR; r.consumed = 1'b1; end
                 else r.kind = K_BOR;
            "&": if (cc == "&") begin r.kind = K_LAND; r.consumed = 1'b1; end
                 else r.kind = K_BAND;
            ">": if (cc == "=") begin r.kind = K_GE; r.consumed = 1'b1; end
                 else if (cc == ">") begin r.kind = K_SHR; r.consumed = 1'b1; end
                 else r.kind = K_GT;
            "<": if (cc == "=") begin r.kind = K_LE; r.consumed = 1'b1; end
                 else if (cc == "<") begin r.kind = K_SHL; r.consumed = 1'b1; end
                 else r.kind = K_LT;
            "=": if (cc == "=") begin r.kind = K_EQ; r.consumed = 1'b1; end
                 else r.kind = K_ASSIGN;
            default: begin
                r.consumed = 1'b1;
                if (cc == "=") r.kind = K_NE;
                else r.bang = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Text constants hold the first character in the lowest byte.
    function automatic logic kw_match(input logic [63:0] w, input logic [4:0] len,
                                      input logic [63:0] txt, input logic [4:0] tlen);
        logic ok;
        ok = (len == tlen);
        for (int i = 0; i < 8; i++) begin
            if (i < tlen && w[i*8 +: 8] != txt[i*8 +: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic kw_t kw_lookup(input logic [63:0] w, input logic [4:0] len);
        kw_t k;
        k = '0;
        k.hit = 1'b1;
        if      (kw_match(w, len, 64'("tuo"), 5'd3))      k.k1 = K_OUT;
        else if (kw_match(w, len, 64'("ni"), 5'd2))       k.k1 = K_IN;
        else if (kw_match(w, len, 64'("enilteg"), 5'd7))  k.k1 = K_GETL;
        else if (kw_match(w, len, 64'("eniltxen"), 5'd8))
            begin k.k1 = K_CHR; k.val = 4'd10; end
        else if (kw_match(w, len, 64'("tni"), 5'd3))
            begin k.k1 = K_DECL; k.two = 1'b1; k.k2 = K_TINT;  end
        else if (kw_match(w, len, 64'("rahc"), 5'd4))
            begin k.k1 = K_DECL; k.two = 1'b1; k.k2 = K_TCHR;  end
        else if (kw_match(w, len, 64'("gnirts"), 5'd6))
            begin k.k1 = K_DECL; k.two = 1'b1; k.k2 = K_TSTR;  end
        else if (kw_match(w, len, 64'("tsil"), 5'd4))
            begin k.k1 = K_DECL; k.two = 1'b1; k.k2 = K_TLIST; end
        else if (kw_match(w, len, 64'("loob"), 5'd4))
            begin k.k1 = K_DECL; k.two = 1'b1; k.k2 = K_TBOOL; end
        else if (kw_match(w, len, 64'("cnuf"), 5'd4))
            begin k.k1 = K_DECL; k.two = 1'b1; k.k2 = K_TFUNC; end
        else if (kw_match(w, len, 64'("fi"), 5'd2))       k.k1 = K_IF;
        else if (kw_match(w, len, 64'("esle"), 5'd4))     k.k1 = K_ELSE;
        else if (kw_match(w, len, 64'("rof"), 5'd3))      k.k1 = K_FOR;
        else if (kw_match(w, len, 64'("elihw"), 5'd5))    k.k1 = K_WHILE;
        else if (kw_match(w, len, 64'("eurt"), 5'd4))
            begin k.k1 = K_BOOLV; k.val = 4'd1; end
        else if (kw_match(w, len, 64'("eslaf"), 5'd5))    k.k1 = K_BOOLV;
        else if (kw_match(w, len, 64'("nruter"), 5'd6))   k.k1 = K_RET;
        else k.hit = 1'b0;
        return k;
    endfunction

    function automatic job_t add_tok(input job_t j, input logic [5:0] k,
                                     input logic [30:0] v, input logic [2:0] e);
        job_t r;
        r = j;
        r.tok[j.ntok] = '{kind: k, value: v, err: e};
        r.ntok = j.ntok + 2'd1;
        return r;
    endfunction

endpackage

// File: hdl/srclex_front.sv
// ----------------------------------------------------------------------------
// srclex_front
// Accepts characters, tracks the lexer mode and turns each character into a
// request that lists the tokens it completes.
// ----------------------------------------------------------------------------
module srclex_front #(
    parameter int KC = 8,
    parameter int VB = 31
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    cmd,
    input  logic [7:0]              ch,
    input  logic                    q_full,
    output logic                    push,
    output srclex_pkg::job_t        job,
    output logic [KC*8-1:0]         jbuf
);
    import srclex_pkg::*;

    localparam int LW = $clog2(KC + 1);
    localparam int IW = $clog2(KC);

    mode_t           mode_reg, mode_next;
    logic [2:0]      err_reg, err_next;
    logic [VB-1:0]   accum_reg, accum_next;
    logic [LW-1:0]   len_reg, len_next;
    logic            ovf_reg, ovf_next;
    logic [7:0]      pend_reg, pend_next;
    logic            lcnt_reg, lcnt_next;
    logic [7:0]      lch_reg, lch_next;
    logic [7:0]      buf_reg [KC];

    logic            accept;
    logic            wr_en;
    logic [IW-1:0]   wr_idx;
    logic [VB+3:0]   num_v;
    logic            num_ovf;
    logic [63:0]     w8;
    kw_t             kw;
    st_t             sc;
    rp_t             rp;
    job_t            fin;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign num_v   = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                   + (VB+4)'(ch[3:0]);
    assign num_ovf = |num_v[VB+3:VB];
    assign sc      = start_class(ch);
    assign rp      = resolve_op(pend_reg, ch, cmd);

    always_comb
    begin
        for (int i = 0; i < 8; i++) w8[i*8 +: 8] = buf_reg[i];
        for (int i = 0; i < KC; i++) jbuf[i*8 +: 8] = buf_reg[i];
    end

    assign kw = kw_lookup(w8, 5'(len_reg));

    always_comb
    begin
        fin = '0;
        if (ovf_reg) begin
            fin = add_tok(fin, K_IDENT, '0, E_NONE);
        end else if (kw.hit) begin
            fin = add_tok(fin, kw.k1, 31'(kw.val), E_NONE);
            if (kw.two) fin = add_tok(fin, kw.k2, '0, E_NONE);
        end else begin
            fin.nflush = 5'(len_reg);
            fin = add_tok(fin, K_IDENT, '0, E_NONE);
        end
    end

    // Next state.
    always_comb
    begin
        logic do_start;
        do_start   = 1'b0;
        mode_next  = mode_reg;
        err_next   = err_reg;
        accum_next = accum_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        pend_next  = pend_reg;
        lcnt_next  = lcnt_reg;
        lch_next   = lch_reg;
        wr_en      = 1'b0;
        wr_idx     = len_reg[IW-1:0];
        if (accept && mode_reg != M_HALT) begin
            if (cmd) begin
                mode_next  = M_IDLE;
                accum_next = '0;
                len_next   = '0;
                ovf_next   = 1'b0;
                pend_next  = '0;
                lcnt_next  = 1'b0;
                lch_next   = '0;
                case (mode_reg)
                    M_STRING:  begin mode_next = M_HALT; err_next = E_OPEN_STR; end
                    M_CHARLIT: begin mode_next = M_HALT; err_next = E_OPEN_CHR; end
                    M_PENDING:
                        if (rp.bang) begin mode_next = M_HALT; err_next = E_BANG; end
                    default: mode_next = M_IDLE;
                endcase
            end else begin
                case (mode_reg)
                    M_COMMENT: mode_next = M_COMMENT;
                    M_NUMBER:
                        if (is_digit(ch)) begin
                            if (num_ovf) begin
                                mode_next = M_HALT;
                                err_next  = E_OVERFLOW;
                            end else begin
                                accum_next = num_v[VB-1:0];
                            end
                        end else begin
                            do_start = 1'b1;
                        end
                    M_WORD:
                        if (is_word(ch)) begin
                            if (!ovf_reg) begin
                                if (len_reg < LW'(KC)) begin
                                    wr_en    = 1'b1;
                                    len_next = len_reg + 1'b1;
                                end else begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end else begin
                            do_start = 1'b1;
                        end
                    M_STRING:
                        if (ch == "\"") mode_next = M_IDLE;
                    M_CHARLIT:
                        if (ch == "'") begin
                            mode_next = M_IDLE;
                        end else if (!lcnt_reg) begin
                            lch_next  = ch;
                            lcnt_next = 1'b1;
                        end else begin
                            mode_next = M_HALT;
                            err_next  = E_LONG_CHR;
                        end
                    M_PENDING:
                    begin
                        pend_next = '0;
                        mode_next = M_IDLE;
                        if (rp.bang) begin
                            mode_next = M_HALT;
                            err_next  = E_BANG;
                        end else if (!rp.consumed) begin
                            do_start = 1'b1;
                        end
                    end
                    default: do_start = 1'b1;
                endcase
                if (do_start) begin
                    mode_next = sc.mode;
                    case (sc.mode)
                        M_NUMBER:  accum_next = VB'(ch[3:0]);
                        M_WORD:
                        begin
                            len_next = LW'(1);
                            ovf_next = 1'b0;
                            wr_en    = 1'b1;
                            wr_idx   = '0;
                        end
                        M_CHARLIT: begin lcnt_next = 1'b0; lch_next = '0; end
                        M_PENDING: pend_next = ch;
                        default: mode_next = sc.mode;
                    endcase
                end
            end
        end
    end

    // Request contents.
    always_comb
    begin
        logic emit_start;
        emit_start = 1'b0;
        job = '0;
        if (mode_reg == M_HALT) begin
            job = add_tok(job, K_FAULT, '0, err_reg);
        end else if (cmd) begin
            case (mode_reg)
                M_NUMBER:  job = add_tok(job, K_INT, 31'(accum_reg), E_NONE);
                M_WORD:    job = fin;
                M_STRING:  job = add_tok(job, K_FAULT, '0, E_OPEN_STR);
                M_CHARLIT: job = add_tok(job, K_FAULT, '0, E_OPEN_CHR);
                M_PENDING:
                    if (rp.bang) job = add_tok(job, K_FAULT, '0, E_BANG);
                    else job = add_tok(job, rp.kind, '0, E_NONE);
                default: job = '0;
            endcase
            if (mode_reg != M_STRING && mode_reg != M_CHARLIT
                    && !(mode_reg == M_PENDING && rp.bang))
                job = add_tok(job, K_END, '0, E_NONE);
        end else begin
            case (mode_reg)
                M_NUMBER:
                    if (is_digit(ch)) begin
                        if (num_ovf) job = add_tok(job, K_FAULT, '0, E_OVERFLOW);
                    end else begin
                        job = add_tok(job, K_INT, 31'(accum_reg), E_NONE);
                        emit_start = 1'b1;
                    end
                M_WORD:
                    if (is_word(ch)) begin
                        if (ovf_reg) begin
                            job = add_tok(job, K_IDCH, 31'(ch), E_NONE);
                        end else if (len_reg >= LW'(KC)) begin
                            job.nflush = 5'(KC);
                            job = add_tok(job, K_IDCH, 31'(ch), E_NONE);
                        end
                    end else begin
                        job = fin;
                        emit_start = 1'b1;
                    end
                M_STRING:
                    if (ch == "\"") job = add_tok(job, K_STR, '0, E_NONE);
                    else job = add_tok(job, K_STRCH, 31'(ch), E_NONE);
                M_CHARLIT:
                    if (ch == "'") job = add_tok(job, K_CHR, 31'(lch_reg), E_NONE);
                    else if (lcnt_reg) job = add_tok(job, K_FAULT, '0, E_LONG_CHR);
                M_PENDING:
                    if (rp.bang) begin
                        job = add_tok(job, K_FAULT, '0, E_BANG);
                    end else begin
                        job = add_tok(job, rp.kind, '0, E_NONE);
                        emit_start = !rp.consumed;
                    end
                M_COMMENT: job = '0;
                default: emit_start = 1'b1;
            endcase
            if (emit_start && sc.emit) job = add_tok(job, sc.kind, '0, E_NONE);
        end
        push = accept && (job.ntok != 2'd0 || job.nflush != 5'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_IDLE;
            err_reg   <= E_NONE;
            accum_reg <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= '0;
            lcnt_reg  <= 1'b0;
            lch_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            err_reg   <= err_next;
            accum_reg <= accum_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            lcnt_reg  <= lcnt_next;
            lch_reg   <= lch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) buf_reg[wr_idx] <= ch;
    end

endmodule

// File: hdl/srclex_queue.sv
// ----------------------------------------------------------------------------
// srclex_queue
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module srclex_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         q_valid,
    output logic         q_full
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;

    assign q_valid = cnt_reg != 2'd0;
    assign q_full  = cnt_reg == 2'd2;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// File: hdl/srclex_back.sv
// ----------------------------------------------------------------------------
// srclex_back
// Expands each request into result items, buffered identifier characters
// first and then the listed tokens, through an output register.
// ----------------------------------------------------------------------------
module srclex_back #(
    parameter int KC = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  logic [KC*8+$bits(srclex_pkg::job_t)-1:0] q_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [5:0]                  kind,
    output logic [30:0]                 value,
    output logic [2:0]                  err,
    output logic                        last
);
    import srclex_pkg::*;

    localparam int JW  = $bits(job_t);
    localparam int PW  = $clog2(KC + 4);
    localparam int BIW = $clog2(KC);

    logic [KC*8+JW-1:0] cur_reg, cur_next;
    logic               cur_valid_reg, cur_valid_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic               ov_reg, ov_next;
    tok_t               ot_reg, ot_next;
    logic               ol_reg, ol_next;

    job_t               cj;
    logic [PW-1:0]      nf;
    logic [PW-1:0]      total;
    logic [1:0]         tix;
    logic [7:0]         cbyte;
    tok_t               sel;
    logic               sel_last;
    logic               can_load;
    logic               issue;

    assign cj       = cur_reg[JW-1:0];
    assign nf       = PW'(cj.nflush);
    assign total    = nf + PW'(cj.ntok);
    assign tix      = 2'(pos_reg - nf);
    assign cbyte    = cur_reg[JW + 8*pos_reg[BIW-1:0] +: 8];
    assign sel_last = pos_reg == total - 1'b1;
    assign can_load = !ov_reg || !out_stall;
    assign issue    = cur_valid_reg && can_load;
    assign pop      = q_valid && (!cur_valid_reg || (issue && sel_last));

    always_comb
    begin
        if (pos_reg < nf) sel = '{kind: K_IDCH, value: 31'(cbyte), err: E_NONE};
        else sel = cj.tok[tix];
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        pos_next       = pos_reg;
        if (pop) begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
            pos_next       = '0;
        end else if (issue && sel_last) begin
            cur_valid_next = 1'b0;
        end else if (issue) begin
            pos_next = pos_reg + 1'b1;
        end
        ov_next = ov_reg;
        ot_next = ot_reg;
        ol_next = ol_reg;
        if (issue) begin
            ov_next = 1'b1;
            ot_next = sel;
            ol_next = sel_last;
        end else if (can_load) begin
            ov_next = 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign kind      = ot_reg.kind;
    assign value     = ot_reg.value;
    assign err       = ot_reg.err;
    assign last      = ol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            ov_reg        <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ot_reg  <= ot_next;
        ol_reg  <= ol_next;
    end

endmodule

// File: hdl/source_language_lexer_core.sv
// ----------------------------------------------------------------------------
// source_language_lexer_core
// Streaming lexer: characters in, tokens out, with a front end, a two-entry
// request queue and a token expansion back end.
// ----------------------------------------------------------------------------
// Requests pass the queue and the back end's request and output registers.
// Throughput: one character per cycle while the queue has room; the back end
// sends one result per cycle while the output is not stalled, so a character
// that gives several results can hold the front end once the queue fills.
// Reset clears all modes and queues at once; no clearing pass is needed.
module source_language_lexer_core #(
    parameter int KEYWORD_CHARS = 8,
    parameter int VALUE_BITS    = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  kind,
    output logic [30:0] value,
    output logic [2:0]  err,
    output logic        last
);
    import srclex_pkg::*;

    localparam int QW = KEYWORD_CHARS * 8 + $bits(job_t);

    logic                     push;
    job_t                     job;
    logic [KEYWORD_CHARS*8-1:0] jbuf;
    logic                     pop;
    logic [QW-1:0]            q_data;
    logic                     q_valid;
    logic                     q_full;

    srclex_front #(.KC(KEYWORD_CHARS), .VB(VALUE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .ch(ch), .q_full(q_full), .push(push), .job(job), .jbuf(jbuf)
    );

    srclex_queue #(.W(QW)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata({jbuf, job}), .pop(pop),
        .rdata(q_data), .q_valid(q_valid), .q_full(q_full)
    );

    srclex_back #(.KC(KEYWORD_CHARS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .value(value),
        .err(err), .last(last)
    );

endmodule

// File: hdl/srclex_checker.sv
// ----------------------------------------------------------------------------
// srclex_checker
// Port-level checks on the lexer result stream.
// ----------------------------------------------------------------------------
module srclex_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        cmd,
    input logic [7:0]  ch,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  kind,
    input logic [30:0] value,
    input logic [2:0]  err,
    input logic        last
);
    import srclex_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value)
            && $stable(err) && $stable(last))
        else $error("stalled result changed");

    a_err_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != K_FAULT |-> err == E_NONE)
        else $error("error code on a normal token");

    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == K_FAULT |-> err != E_NONE && value == 31'd0 && last)
        else $error("malformed fault result");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == K_END |-> last && value == 31'd0)
        else $error("end token not last");

endmodule

bind source_language_lexer_core srclex_checker u_chk (.*);

// File: bench/source_language_lexer_checker.sv
// ----------------------------------------------------------------------------
// source_language_lexer_checker
// Watches the request and token channels of the source lexer, predicts the
// tokens of every accepted request and compares them field by field in order.
// ----------------------------------------------------------------------------
module source_language_lexer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  ch,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  kind,
    input  logic [30:0] value,
    input  logic [2:0]  err,
    input  logic        last,
    output int          fail_count,
    output int          pending_tokens
);
    import srclex_pkg::*;

    typedef struct {
        logic [5:0]  kind;
        logic [30:0] value;
        logic [2:0]  err;
        logic        last;
    } token_t;

    token_t tokens_due[$];
    token_t batch[$];

    mode_t       mode;
    logic [2:0]  halt_code;
    logic [31:0] number;
    logic [7:0]  word[8];
    int          word_len;
    logic        word_long;
    logic [7:0]  op_char;
    int          lit_count;
    logic [7:0]  lit_char;

    function automatic logic digit_c(logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic alpha_c(logic [7:0] c);
        return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
    endfunction

    function automatic void put(logic [5:0] k, logic [30:0] v, logic [2:0] e);
        token_t t;
        t.kind = k;
        t.value = v;
        t.err = e;
        t.last = 1'b0;
        batch = {batch, t};
    endfunction

    function automatic void stop_with(logic [2:0] e);
        put(K_FAULT, 0, e);
        mode = M_HALT;
        halt_code = e;
    endfunction

    task automatic clear_lexer();
        mode = M_IDLE;
        number = 0;
        word_len = 0;
        word_long = 1'b0;
        op_char = 0;
        lit_count = 0;
        lit_char = 0;
    endtask

    task automatic flush_word();
        for (int i = 0; i < word_len && i < 8; i++)
            put(K_IDCH, 31'(word[i]), E_NONE);
    endtask

    task automatic grow_word(logic [7:0] c);
        if (word_long) begin
            put(K_IDCH, 31'(c), E_NONE);
        end else if (word_len < 8) begin
            word[word_len] = c;
            word_len++;
        end else begin
            flush_word();
            put(K_IDCH, 31'(c), E_NONE);
            word_long = 1'b1;
        end
    endtask

    function automatic logic word_is(string s);
        if (s.len() != word_len)
            return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (word[i] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic end_word();
        mode = M_IDLE;
        if (!word_long) begin
            if (word_is("out")) begin put(K_OUT, 0, E_NONE); return; end
            if (word_is("in")) begin put(K_IN, 0, E_NONE); return; end
            if (word_is("getline")) begin put(K_GETL, 0, E_NONE); return; end
            if (word_is("nextline")) begin put(K_CHR, 10, E_NONE); return; end
            if (word_is("int"))
            begin put(K_DECL, 0, E_NONE); put(K_TINT, 0, E_NONE); return; end
            if (word_is("char"))
            begin put(K_DECL, 0, E_NONE); put(K_TCHR, 0, E_NONE); return; end
            if (word_is("string"))
            begin put(K_DECL, 0, E_NONE); put(K_TSTR, 0, E_NONE); return; end
            if (word_is("list"))
            begin put(K_DECL, 0, E_NONE); put(K_TLIST, 0, E_NONE); return; end
            if (word_is("bool"))
            begin put(K_DECL, 0, E_NONE); put(K_TBOOL, 0, E_NONE); return; end
            if (word_is("func"))
            begin put(K_DECL, 0, E_NONE); put(K_TFUNC, 0, E_NONE); return; end
            if (word_is("if")) begin put(K_IF, 0, E_NONE); return; end
            if (word_is("else")) begin put(K_ELSE, 0, E_NONE); return; end
            if (word_is("for")) begin put(K_FOR, 0, E_NONE); return; end
            if (word_is("while")) begin put(K_WHILE, 0, E_NONE); return; end
            if (word_is("true")) begin put(K_BOOLV, 1, E_NONE); return; end
            if (word_is("false")) begin put(K_BOOLV, 0, E_NONE); return; end
            if (word_is("return")) begin put(K_RET, 0, E_NONE); return; end
            flush_word();
        end
        put(K_IDENT, 0, E_NONE);
    endtask

    task automatic open_token(logic [7:0] c);
        mode = M_IDLE;
        if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13))
            return;
        if (digit_c(c)) begin
            number = 32'(c - 8'd48);
            mode = M_NUMBER;
            return;
        end
        if (alpha_c(c) || c == "_") begin
            word_len = 0;
            word_long = 1'b0;
            mode = M_WORD;
            grow_word(c);
            return;
        end
        case (c)
            "#": mode = M_COMMENT;
            "\"": mode = M_STRING;
            "'": begin lit_count = 0; lit_char = 0; mode = M_CHARLIT; end
            "|", "&", ">", "<", "=", "!": begin op_char = c; mode = M_PENDING; end
            ";": put(K_SEMI, 0, E_NONE);
            "[": put(K_LBRACK, 0, E_NONE);
            "]": put(K_RBRACK, 0, E_NONE);
            "{": put(K_LBRACE, 0, E_NONE);
            "}": put(K_RBRACE, 0, E_NONE);
            ",": put(K_COMMA, 0, E_NONE);
            "%": put(K_MOD, 0, E_NONE);
            "^": put(K_XOR, 0, E_NONE);
            "(": put(K_LPAR, 0, E_NONE);
            ")": put(K_RPAR, 0, E_NONE);
            "+": put(K_ADD, 0, E_NONE);
            "-": put(K_SUB, 0, E_NONE);
            "*": put(K_MUL, 0, E_NONE);
            "/": put(K_DIV, 0, E_NONE);
            default: ;
        endcase
    endtask

    // Returns 1 when the lookahead character was used by the operator, or when a lone ! halts.
    function automatic logic settle_op(logic [7:0] c, logic at_end);
        logic [7:0] p;
        p = op_char;
        mode = M_IDLE;
        op_char = 0;
        if (at_end)
            c = 0;
        case (p)
            "|": begin
                if (c == "|") begin put(K_LOR, 0, E_NONE); return 1'b1; end
                put(K_BOR, 0, E_NONE);
            end
            "&": begin
                if (c == "&") begin put(K_LAND, 0, E_NONE); return 1'b1; end
                put(K_BAND, 0, E_NONE);
            end
            ">": begin
                if (c == "=") begin put(K_GE, 0, E_NONE); return 1'b1; end
                if (c == ">") begin put(K_SHR, 0, E_NONE); return 1'b1; end
                put(K_GT, 0, E_NONE);
            end
            "<": begin
                if (c == "=") begin put(K_LE, 0, E_NONE); return 1'b1; end
                if (c == "<") begin put(K_SHL, 0, E_NONE); return 1'b1; end
                put(K_LT, 0, E_NONE);
            end
            "=": begin
                if (c == "=") begin put(K_EQ, 0, E_NONE); return 1'b1; end
                put(K_ASSIGN, 0, E_NONE);
            end
            default: begin
                if (c == "=") put(K_NE, 0, E_NONE);
                else stop_with(E_BANG);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic lex_request(logic end_mark, logic [7:0] c);
        logic [31:0] grown;
        batch.delete();
        if (mode == M_HALT) begin
            put(K_FAULT, 0, halt_code);
        end else if (end_mark) begin
            case (mode)
                M_NUMBER: put(K_INT, number[30:0], E_NONE);
                M_WORD: end_word();
                M_STRING: stop_with(E_OPEN_STR);
                M_CHARLIT: stop_with(E_OPEN_CHR);
                M_PENDING: void'(settle_op(0, 1'b1));
                default: ;
            endcase
            if (mode != M_HALT) begin
                put(K_END, 0, E_NONE);
                clear_lexer();
            end
        end else begin
            case (mode)
                M_COMMENT: ;
                M_NUMBER: begin
                    if (digit_c(c)) begin
                        grown = number * 10 + 32'(c - 8'd48);
                        if (number > 32'd214748364 || grown > 32'h7FFF_FFFF)
                            stop_with(E_OVERFLOW);
                        else
                            number = grown;
                    end else begin
                        put(K_INT, number[30:0], E_NONE);
                        open_token(c);
                    end
                end
                M_WORD: begin
                    if (alpha_c(c) || digit_c(c) || c == "_") begin
                        grow_word(c);
                    end else begin
                        end_word();
                        open_token(c);
                    end
                end
                M_STRING: begin
                    if (c == "\"") begin put(K_STR, 0, E_NONE); mode = M_IDLE; end
                    else put(K_STRCH, 31'(c), E_NONE);
                end
                M_CHARLIT: begin
                    if (c == "'") begin
                        put(K_CHR, 31'(lit_char), E_NONE);
                        mode = M_IDLE;
                    end else if (lit_count == 0) begin
                        lit_char = c;
                        lit_count = 1;
                    end else begin
                        stop_with(E_LONG_CHR);
                    end
                end
                M_PENDING: begin
                    if (!settle_op(c, 1'b0))
                        open_token(c);
                end
                default: open_token(c);
            endcase
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            tokens_due = {tokens_due, batch[i]};
    endtask

    task automatic report(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending_tokens = 0;
        halt_code = E_NONE;
        clear_lexer();
    end

    always @(posedge clk)
    begin
        token_t t;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (tokens_due.size() == 0) begin
                    report($sformatf("unexpected token kind %0d value %0d", kind, value));
                end else begin
                    t = tokens_due.pop_front();
                    if (kind !== t.kind)
                        report($sformatf("kind %0d, expected %0d", kind, t.kind));
                    if (value !== t.value)
                        report($sformatf("value %0d, expected %0d (kind %0d)",
                                         value, t.value, t.kind));
                    if (err !== t.err)
                        report($sformatf("err %0d, expected %0d", err, t.err));
                    if (last !== t.last)
                        report($sformatf("last %0b, expected %0b (kind %0d)",
                                         last, t.last, t.kind));
                end
            end
            if (in_valid && !in_stall)
                lex_request(cmd, ch);
            pending_tokens = tokens_due.size();
        end
    end

endmodule

// File: bench/tb_source_language_lexer_core.sv
// ----------------------------------------------------------------------------
// tb_source_language_lexer_core
// Drives directed and random source text through the lexer with random gaps
// and stalls, including a long output hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_source_language_lexer_core;
    import srclex_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  kind;
    logic [30:0] value;
    logic [2:0]  err;
    logic        last;
    int          fail_count;
    int          pending_tokens;
    logic        quiet_tail;
    logic        hold_off;
    int          idle_cycles;

    typedef struct {
        logic       end_mark;
        logic [7:0] c;
    } request_t;

    request_t text[$];

    source_language_lexer_core DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .ch(ch), .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .value(value), .err(err), .last(last)
    );

    source_language_lexer_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .ch(ch), .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .value(value), .err(err), .last(last),
        .fail_count(fail_count), .pending_tokens(pending_tokens)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic add_text(string s);
        request_t r;
        for (int i = 0; i < s.len(); i++) begin
            r.end_mark = 1'b0;
            r.c = s[i];
            text = {text, r};
        end
    endtask

    task automatic add_byte(logic [7:0] b);
        request_t r;
        r.end_mark = 1'b0;
        r.c = b;
        text = {text, r};
    endtask

    task automatic add_end();
        request_t r;
        r.end_mark = 1'b1;
        r.c = 8'($urandom);
        text = {text, r};
    endtask

    function automatic string random_word();
        string words[24];
        string s;
        words = '{"out", "in", "getline", "nextline", "int", "char", "string",
                  "list", "bool", "func", "if", "else", "for", "while", "true",
                  "false", "return", "x", "_a9", "count", "longername",
                  "outer", "Abcdefgh", "zZ_09qwertyu"};
        s = words[$urandom_range(0, 23)];
        return s;
    endfunction

    function automatic string random_piece();
        string ops[22];
        string s;
        ops = '{"||", "|", "&&", "&", ">=", ">>", ">", "<=", "<<", "<", "==",
                "=", "!=", ";", "[", "]", "{", "}", ",", "%^", "()", "+-*/"};
        case ($urandom_range(0, 7))
            0, 1: s = random_word();
            2: s = $sformatf("%0d", $urandom_range(0, 2000000000));
            3: s = ops[$urandom_range(0, 21)];
            4: s = "\"str ing\"";
            5: s = ($urandom_range(0, 1)) ? "'q'" : "''";
            6: s = " ";
            default: s = "\t\n";
        endcase
        return s;
    endfunction

    // Builds a run of text: mostly well-formed, sometimes with noise or with
    // numbers run together that overflow and halt the lexer until the next reset.
    task automatic build_random();
        int n;
        while (text.size() < 230) begin
            n = $urandom_range(3, 10);
            for (int i = 0; i < n; i++) begin
                add_text(random_piece());
                add_text(($urandom_range(0, 2) == 0) ? "" : " ");
                if ($urandom_range(0, 15) == 0)
                    add_byte(8'($urandom_range(128, 255)));
                if ($urandom_range(0, 15) == 0)
                    add_byte(8'($urandom_range(0, 8)));
            end
            if ($urandom_range(0, 9) == 0)
                add_text("# comment ~");
            add_end();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int gap;
        out_stall <= 1'b0;
        @(posedge rst_n);
        while (!quiet_tail) begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (150) @(posedge clk);
                out_stall <= 1'b0;
                wait (!hold_off);
            end else if ($urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        out_stall <= 1'b0;
    end

    initial
    begin
        request_t r;
        int sent;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = 1'b0;
        ch = 8'd0;
        quiet_tail = 1'b0;
        hold_off = 1'b0;

        add_text("out in getline nextline int char string list bool func ");
        add_text("if else for while true false return abc_12345xyz ");
        add_text("|| | && & >= >> > <= << < == = != ; [ ] { } , % ^ ( ) + - * / ");
        add_text("2147483647 0 \"s\x01\xff\" '' 'a' ");
        add_byte(8'd200);
        add_byte(8'd0);
        add_byte(8'd127);
        add_text("<");
        add_end();
        add_text("! ");
        add_end();
        add_text("2147483648");
        add_end();
        add_text("\"open");
        add_end();
        add_text("'a");
        add_end();
        add_text("'ab'");
        add_end();
        add_text("!");
        add_end();
        build_random();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        sent = 0;
        while (text.size() > 0) begin
            r = text.pop_front();
            if (sent == 60)
                hold_off <= 1'b1;
            if (sent == 100)
                hold_off <= 1'b0;
            if (sent == text.size() + sent - 40)
                quiet_tail <= 1'b1;
            if (!quiet_tail && !hold_off && $urandom_range(0, 6) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            in_valid <= 1'b1;
            cmd <= r.end_mark;
            ch <= r.c;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            sent++;
        end
        in_valid <= 1'b0;
        quiet_tail <= 1'b1;
        hold_off <= 1'b0;

        while (pending_tokens > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: source_language_lexer_core.f
hdl/srclex_pkg.sv
hdl/srclex_front.sv
hdl/srclex_queue.sv
hdl/srclex_back.sv
hdl/source_language_lexer_core.sv
hdl/srclex_checker.sv
bench/source_language_lexer_checker.sv
bench/tb_source_language_lexer_core.sv
